// File: hdl/gimli_pkg.sv
// Gimli package: state type, round constants and the single-round function.
// Used by the channel interfaces and by the permutation pipeline.
// No dependencies.
package gimli_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned NUM_WORDS  = 12;
    localparam int unsigned NUM_ROUNDS = 24;
    localparam int unsigned ROUND_W    = 5;

    localparam logic [WORD_W-1:0] ROUND_CONST = 32'h9e37_7900;

    // Round codes by their position in the group of four rounds.
    localparam logic [1:0] PHASE_SMALL_SWAP = 2'd0;
    localparam logic [1:0] PHASE_BIG_SWAP   = 2'd2;

    typedef logic [WORD_W-1:0]                word_t;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;
    typedef logic [ROUND_W-1:0]               round_t;

    // One Gimli round: SP-box on each column, then the swap and constant
    // that the round number calls for.
    function automatic state_t gimli_round(state_t st, round_t rnd);
        state_t t;
        word_t  x;
        word_t  y;
        word_t  z;
        word_t  tmp;
        t = st;
        for (int c = 0; c < 4; c++)
        begin
            x = {t[c][7:0], t[c][31:8]};
            y = {t[4+c][22:0], t[4+c][31:23]};
            z = t[8+c];
            t[8+c] = x ^ (z << 1) ^ ((y & z) << 2);
            t[4+c] = y ^ x ^ ((x | z) << 1);
            t[c]   = z ^ y ^ ((x & y) << 3);
        end
        case (rnd[1:0])
            PHASE_SMALL_SWAP:
            begin
                tmp  = t[0];
                t[0] = t[1];
                t[1] = tmp;
                tmp  = t[2];
                t[2] = t[3];
                t[3] = tmp;
                t[0] = t[0] ^ ROUND_CONST ^ {{(WORD_W-ROUND_W){1'b0}}, rnd};
            end
            PHASE_BIG_SWAP:
            begin
                tmp  = t[0];
                t[0] = t[2];
                t[2] = tmp;
                tmp  = t[1];
                t[1] = t[3];
                t[3] = tmp;
            end
            default:
            begin
                t = t;
            end
        endcase
        return t;
    endfunction

endpackage

// File: hdl/gimli_if.sv
// Valid/ready channel interfaces for the Gimli permutation: the state
// going in and the permuted state coming out. Depends on gimli_pkg.
interface gimli_in_if
    import gimli_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t in_word_0;
    word_t in_word_1;
    word_t in_word_2;
    word_t in_word_3;
    word_t in_word_4;
    word_t in_word_5;
    word_t in_word_6;
    word_t in_word_7;
    word_t in_word_8;
    word_t in_word_9;
    word_t in_word_10;
    word_t in_word_11;

    modport source (
        output valid, in_word_0, in_word_1, in_word_2, in_word_3, in_word_4,
               in_word_5, in_word_6, in_word_7, in_word_8, in_word_9,
               in_word_10, in_word_11,
        input  ready
    );
    modport sink (
        input  valid, in_word_0, in_word_1, in_word_2, in_word_3, in_word_4,
               in_word_5, in_word_6, in_word_7, in_word_8, in_word_9,
               in_word_10, in_word_11,
        output ready
    );
endinterface

interface gimli_out_if
    import gimli_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t out_word_0;
    word_t out_word_1;
    word_t out_word_2;
    word_t out_word_3;
    word_t out_word_4;
    word_t out_word_5;
    word_t out_word_6;
    word_t out_word_7;
    word_t out_word_8;
    word_t out_word_9;
    word_t out_word_10;
    word_t out_word_11;

    modport source (
        output valid, out_word_0, out_word_1, out_word_2, out_word_3, out_word_4,
               out_word_5, out_word_6, out_word_7, out_word_8, out_word_9,
               out_word_10, out_word_11,
        input  ready
    );
    modport sink (
        input  valid, out_word_0, out_word_1, out_word_2, out_word_3, out_word_4,
               out_word_5, out_word_6, out_word_7, out_word_8, out_word_9,
               out_word_10, out_word_11,
        output ready
    );
endinterface

// File: hdl/gimli_permutation.sv
// Gimli-384 permutation, one round per pipeline stage, with a two-entry
// output buffer. Depends on gimli_pkg and the channels in gimli_if.sv.
//
//   channel   role     payload                      transfer
//   load      sink     in_word_0 .. in_word_11      valid && ready
//   result    source   out_word_0 .. out_word_11    valid && ready
//
// A loaded state passes through 24 round stages, each holding one round of
// SP-boxes and swaps, and then through the output register.
// One state enters every cycle while the output side keeps taking results.
// Reset (rst_n, asynchronous) clears only the valid bits of the stages and of the output buffer.
// A stall on the result side fills the spare output entry first; the rounds
// freeze only then, so a waiting result does not stop the next load.
module gimli_permutation
    import gimli_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    gimli_in_if.sink    load,
    gimli_out_if.source result
);

    // Pipeline stages: stage i holds the state after round 24 - i.
    logic   [NUM_ROUNDS-1:0] valid_reg;
    state_t                  data_reg [NUM_ROUNDS];
    state_t                  round_next [NUM_ROUNDS];

    // Output entry and spare entry.
    logic   out_valid_reg;
    state_t out_data_reg;
    logic   spare_valid_reg;
    state_t spare_data_reg;

    state_t load_state;
    logic   advance;
    logic   push;

    // Gather the input words into one state.
    assign load_state = {load.in_word_11, load.in_word_10, load.in_word_9,
                         load.in_word_8,  load.in_word_7,  load.in_word_6,
                         load.in_word_5,  load.in_word_4,  load.in_word_3,
                         load.in_word_2,  load.in_word_1,  load.in_word_0};

    // The rounds move whenever the spare entry is free.
    assign advance    = ~spare_valid_reg;
    assign load.ready = advance;
    assign push       = advance & valid_reg[NUM_ROUNDS-1];

    // Round logic for each stage; rounds count down from 24.
    generate
        for (genvar i = 0; i < NUM_ROUNDS; i++)
        begin : g_round
            localparam round_t RND = round_t'(NUM_ROUNDS - i);
            if (i == 0)
            begin : g_first
                assign round_next[i] = gimli_round(load_state, RND);
            end
            else
            begin : g_rest
                assign round_next[i] = gimli_round(data_reg[i-1], RND);
            end
        end
    endgenerate

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[NUM_ROUNDS-2:0], load.valid};
        end
    end

    // Stage data.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < NUM_ROUNDS; i++)
            begin
                data_reg[i] <= round_next[i];
            end
        end
    end

    // Output buffer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (spare_valid_reg)
        begin
            if (result.ready)
            begin
                spare_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !result.ready)
            begin
                spare_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output buffer data.
    always_ff @(posedge clk)
    begin
        if (spare_valid_reg)
        begin
            if (result.ready)
            begin
                out_data_reg <= spare_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !result.ready)
            begin
                spare_data_reg <= data_reg[NUM_ROUNDS-1];
            end
            else
            begin
                out_data_reg <= data_reg[NUM_ROUNDS-1];
            end
        end
    end

    // Result channel.
    assign result.valid       = out_valid_reg;
    assign result.out_word_0  = out_data_reg[0];
    assign result.out_word_1  = out_data_reg[1];
    assign result.out_word_2  = out_data_reg[2];
    assign result.out_word_3  = out_data_reg[3];
    assign result.out_word_4  = out_data_reg[4];
    assign result.out_word_5  = out_data_reg[5];
    assign result.out_word_6  = out_data_reg[6];
    assign result.out_word_7  = out_data_reg[7];
    assign result.out_word_8  = out_data_reg[8];
    assign result.out_word_9  = out_data_reg[9];
    assign result.out_word_10 = out_data_reg[10];
    assign result.out_word_11 = out_data_reg[11];

endmodule

// File: tb/gimli_permutation_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for gimli_permutation: drives whole 384-bit states,
// predicts each permuted state and checks every result transfer in order.
// Depends on gimli_pkg and the channel interfaces in gimli_if.sv.
module gimli_permutation_tb;
    import gimli_pkg::*;

    localparam int unsigned RANDOM_STATES  = 1335;
    localparam int unsigned DRAIN_CYCLES   = 40;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;

    gimli_in_if  load_ch();
    gimli_out_if result_ch();

    gimli_permutation u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load_ch),
        .result (result_ch)
    );

    // States waiting to be loaded and permuted states waiting to come back.
    state_t states_to_load[$];
    state_t permuted_expected[$];

    int unsigned states_total;
    int unsigned states_loaded;
    int unsigned mismatch_count;
    int unsigned idle_cycles;
    int unsigned load_gap;
    int unsigned result_stall;
    int unsigned calm_left;
    logic        load_taken;

    // Rotate a word left by n bits, 0 < n < 32.
    function automatic word_t rotate_left(input word_t v, input int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // Full 24-round Gimli permutation of one state.
    function automatic state_t permute_state(input state_t s);
        state_t st;
        word_t  x;
        word_t  y;
        word_t  z;
        word_t  held;
        round_t rnd;
        st = s;
        for (int r = NUM_ROUNDS; r > 0; r--)
        begin
            rnd = round_t'(r);
            // Column SP-box on all four columns.
            for (int c = 0; c < 4; c++)
            begin
                x = rotate_left(st[c], 24);
                y = rotate_left(st[4+c], 9);
                z = st[8+c];
                st[8+c] = x ^ (z << 1) ^ ((y & z) << 2);
                st[4+c] = y ^ x ^ ((x | z) << 1);
                st[c]   = z ^ y ^ ((x & y) << 3);
            end
            // Row-0 swaps and the round constant.
            if (rnd[1:0] == PHASE_SMALL_SWAP)
            begin
                held  = st[0];
                st[0] = st[1] ^ ROUND_CONST ^ word_t'(rnd);
                st[1] = held;
                held  = st[2];
                st[2] = st[3];
                st[3] = held;
            end
            else if (rnd[1:0] == PHASE_BIG_SWAP)
            begin
                held  = st[0];
                st[0] = st[2];
                st[2] = held;
                held  = st[1];
                st[1] = st[3];
                st[3] = held;
            end
        end
        return st;
    endfunction

    // Random word, biased toward all-zero, all-one and one-hot values.
    function automatic word_t random_word();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0: return '0;
            1: return '1;
            2: return word_t'(1) << $urandom_range(0, WORD_W - 1);
            default: return word_t'($urandom);
        endcase
    endfunction

    // Gap length: mostly none, some short, a few long; none in a calm stretch.
    function automatic int unsigned gap_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm_left > 0)
            return 0;
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Driver: load transfers and result backpressure, updated at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 299) == 0)
                calm_left = $urandom_range(50, 200);

            if (!load_ch.valid || load_taken)
            begin
                if (load_gap > 0)
                begin
                    load_ch.valid <= 1'b0;
                    load_gap--;
                end
                else if (states_to_load.size() > 0)
                begin
                    state_t next_state;
                    next_state = states_to_load.pop_front();
                    load_ch.in_word_0  <= next_state[0];
                    load_ch.in_word_1  <= next_state[1];
                    load_ch.in_word_2  <= next_state[2];
                    load_ch.in_word_3  <= next_state[3];
                    load_ch.in_word_4  <= next_state[4];
                    load_ch.in_word_5  <= next_state[5];
                    load_ch.in_word_6  <= next_state[6];
                    load_ch.in_word_7  <= next_state[7];
                    load_ch.in_word_8  <= next_state[8];
                    load_ch.in_word_9  <= next_state[9];
                    load_ch.in_word_10 <= next_state[10];
                    load_ch.in_word_11 <= next_state[11];
                    load_ch.valid      <= 1'b1;
                    load_gap = gap_length();
                end
                else
                begin
                    load_ch.valid <= 1'b0;
                end
            end

            if (result_stall > 0)
            begin
                result_ch.ready <= 1'b0;
                result_stall--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                result_stall = gap_length();
            end
        end
    end

    // Monitor: checks result transfers, predicts on load transfers, watchdog.
    always @(posedge clk)
    begin
        state_t got;
        state_t want;
        logic   result_taken;
        load_taken   = rst_n && load_ch.valid && load_ch.ready;
        result_taken = rst_n && result_ch.valid && result_ch.ready;

        if (result_taken)
        begin
            got[0]  = result_ch.out_word_0;
            got[1]  = result_ch.out_word_1;
            got[2]  = result_ch.out_word_2;
            got[3]  = result_ch.out_word_3;
            got[4]  = result_ch.out_word_4;
            got[5]  = result_ch.out_word_5;
            got[6]  = result_ch.out_word_6;
            got[7]  = result_ch.out_word_7;
            got[8]  = result_ch.out_word_8;
            got[9]  = result_ch.out_word_9;
            got[10] = result_ch.out_word_10;
            got[11] = result_ch.out_word_11;
            if (permuted_expected.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end
            else
            begin
                want = permuted_expected.pop_front();
                for (int k = 0; k < NUM_WORDS; k++)
                begin
                    if (got[k] !== want[k])
                    begin
                        mismatch_count++;
                        $display("%0t: out_word_%0d expected %08h actual %08h",
                                 $time, k, want[k], got[k]);
                    end
                end
            end
        end

        if (load_taken)
        begin
            want[0]  = load_ch.in_word_0;
            want[1]  = load_ch.in_word_1;
            want[2]  = load_ch.in_word_2;
            want[3]  = load_ch.in_word_3;
            want[4]  = load_ch.in_word_4;
            want[5]  = load_ch.in_word_5;
            want[6]  = load_ch.in_word_6;
            want[7]  = load_ch.in_word_7;
            want[8]  = load_ch.in_word_8;
            want[9]  = load_ch.in_word_9;
            want[10] = load_ch.in_word_10;
            want[11] = load_ch.in_word_11;
            permuted_expected.push_back(permute_state(want));
            states_loaded++;
        end

        if (load_taken || result_taken || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("gimli_permutation test failed");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        state_t s;
        rst_n           = 1'b0;
        load_ch.valid   = 1'b0;
        load_ch.in_word_0  = '0;
        load_ch.in_word_1  = '0;
        load_ch.in_word_2  = '0;
        load_ch.in_word_3  = '0;
        load_ch.in_word_4  = '0;
        load_ch.in_word_5  = '0;
        load_ch.in_word_6  = '0;
        load_ch.in_word_7  = '0;
        load_ch.in_word_8  = '0;
        load_ch.in_word_9  = '0;
        load_ch.in_word_10 = '0;
        load_ch.in_word_11 = '0;
        result_ch.ready = 1'b0;
        load_taken      = 1'b0;
        states_loaded   = 0;
        mismatch_count  = 0;
        idle_cycles     = 0;
        load_gap        = 0;
        result_stall    = 0;
        calm_left       = 100;

        // Directed states: uniform patterns first.
        states_to_load.push_back('0);
        states_to_load.push_back('1);
        states_to_load.push_back({NUM_WORDS{32'haaaa_aaaa}});
        states_to_load.push_back({NUM_WORDS{32'h5555_5555}});
        states_to_load.push_back({NUM_WORDS{32'h8000_0001}});
        // The usual published test state: word i = i^3 + i * 0x9e3779b9.
        for (int i = 0; i < NUM_WORDS; i++)
            s[i] = word_t'(i * i * i) + word_t'(i) * 32'h9e37_79b9;
        states_to_load.push_back(s);
        // One row of ones at a time.
        for (int row = 0; row < 3; row++)
        begin
            s = '0;
            for (int c = 0; c < 4; c++)
                s[4*row+c] = '1;
            states_to_load.push_back(s);
        end
        // One column of ones at a time.
        for (int c = 0; c < 4; c++)
        begin
            s = '0;
            for (int row = 0; row < 3; row++)
                s[4*row+c] = '1;
            states_to_load.push_back(s);
        end
        // Single set bits at the ends of the state, then two adjacent set bits across words 5 and 6.
        s = '0;
        s[0][0] = 1'b1;
        states_to_load.push_back(s);
        s = '0;
        s[NUM_WORDS-1][WORD_W-1] = 1'b1;
        states_to_load.push_back(s);
        s = '0;
        s[5][31] = 1'b1;
        s[6][0]  = 1'b1;
        states_to_load.push_back(s);

        // Random states.
        for (int n = 0; n < RANDOM_STATES; n++)
        begin
            for (int k = 0; k < NUM_WORDS; k++)
                s[k] = random_word();
            states_to_load.push_back(s);
        end
        states_total = states_to_load.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (states_loaded < states_total)
            @(posedge clk);
        while (permuted_expected.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("gimli_permutation test passed");
        else
            $display("gimli_permutation test failed");
        $finish;
    end

endmodule
